>>> sv/ccbd_pkg.sv
// ----------------------------------------------------------------------------
// ccbd_pkg
// Shared types, address map constants and helpers for the CPU bus decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package ccbd_pkg;

  // Size of the main store in bytes
  localparam int STORE_BYTES = 65536;
  localparam int STORE_AW    = $clog2(STORE_BYTES);

  typedef logic [STORE_AW-1:0] store_idx_t;

  localparam store_idx_t STORE_LAST = STORE_AW'(STORE_BYTES - 1);

  // Bus commands
  localparam logic [1:0] CMD_RD_BYTE = 2'd0;
  localparam logic [1:0] CMD_RD_WORD = 2'd1;
  localparam logic [1:0] CMD_WR_BYTE = 2'd2;
  localparam logic [1:0] CMD_NONE    = 2'd3;

  // Result targets
  localparam logic [1:0] TGT_MEM  = 2'd0;
  localparam logic [1:0] TGT_GFX  = 2'd1;
  localparam logic [1:0] TGT_CTRL = 2'd2;
  localparam logic [1:0] TGT_DMA  = 2'd3;

  // Address map
  localparam logic [15:0] RAM_MASK = 16'h07FF;
  localparam logic [15:0] RAM_END  = 16'h2000;
  localparam logic [15:0] GFX_BASE = 16'h2000;
  localparam logic [15:0] GFX_END  = 16'h4000;
  localparam logic [15:0] DMA_PORT = 16'h4014;
  localparam logic [15:0] PAD_PORT = 16'h4016;
  localparam logic [7:0]  PAD_FILL = 8'h80;
  localparam logic [7:0]  PAD_LOAD = 8'h01;
  localparam logic [7:0]  PAD_IDLE = 8'h00;

  // Graphics register numbers with special handling
  localparam logic [2:0] GFX_REG_STATUS = 3'd2;
  localparam logic [2:0] GFX_REG_DATA   = 3'd7;

  typedef enum logic [1:0] {
    SRC_DIRECT = 2'd0,
    SRC_BYTE   = 2'd1,
    SRC_WORD   = 2'd2
  } rd_src_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [7:0]  buttons;
  } in_item_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic [1:0]  target;
    logic [2:0]  register_index;
    logic        register_write;
    logic [7:0]  forward_data;
  } out_item_t;

  // Decoded transaction: store accesses, pad update and direct result
  typedef struct packed {
    logic       mem_we;
    store_idx_t wr_idx;
    logic [7:0] wr_data;
    store_idx_t rd_idx_lo;
    store_idx_t rd_idx_hi;
    rd_src_t    src;
    logic       pad_we;
    logic [7:0] pad_nxt;
    out_item_t  res;
  } dec_t;

  localparam logic [17:0] SPAN1 = 18'(STORE_BYTES);
  localparam logic [17:0] SPAN2 = 18'(2 * STORE_BYTES);
  localparam logic [17:0] SPAN3 = 18'(3 * STORE_BYTES);

  // Bus address modulo store size; the quotient never exceeds three
  function automatic store_idx_t store_index(input logic [15:0] a);
    logic [17:0] w;
    w = {2'b00, a};
    if (w >= SPAN3) begin
      w = w - SPAN3;
    end else if (w >= SPAN2) begin
      w = w - SPAN2;
    end else if (w >= SPAN1) begin
      w = w - SPAN1;
    end
    return w[STORE_AW-1:0];
  endfunction

endpackage

`default_nettype wire

>>> sv/console_cpu_bus_decoder.sv
// ----------------------------------------------------------------------------
// console_cpu_bus_decoder
// CPU bus decoder: RAM and register mirroring, forwarded graphics register
// accesses, controller shift port, DMA request and a byte-wide main store.
// ----------------------------------------------------------------------------
//
//   channel  | ports                 | handshake
//   ---------+-----------------------+------------------------------------
//   input    | start, busy, in_item  | taken when start && !busy
//   result   | out_valid, out_item   | one-cycle strobe, cannot be held off
//
// One transaction per cycle while not busy; its result shows on the cycle
// after it is taken, set by the registered read of the main store RAM.
// Stores take effect at the accepting edge, so the next read sees them.
// After reset busy stays high while the store is cleared to zero, one byte
// per cycle.
// The receiver cannot stall; busy is low at all other times.
// ----------------------------------------------------------------------------
`default_nettype none

module console_cpu_bus_decoder
  import ccbd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire in_item_t in_item,
  output logic          out_valid,
  output out_item_t     out_item
);

  dec_t       dec;
  logic       accept;

  logic       clr_r,     clr_nxt;
  store_idx_t clr_idx_r, clr_idx_nxt;
  logic [7:0] pad_r,     pad_nxt;
  logic       vld_r,     vld_nxt;
  rd_src_t    src_r,     src_nxt;
  out_item_t  res_r,     res_nxt;

  logic       ram_we;
  store_idx_t ram_wr_idx;
  logic [7:0] ram_wr_data;
  logic [7:0] rd_lo;
  logic [7:0] rd_hi;

  assign busy   = clr_r;
  assign accept = start && !clr_r;

  ccbd_decode u_decode (
    .item  (in_item),
    .pad_q (pad_r),
    .dec   (dec)
  );

  // clearing sweep owns the write port until done
  always_comb begin
    if (clr_r) begin
      ram_we      = 1'b1;
      ram_wr_idx  = clr_idx_r;
      ram_wr_data = 8'h00;
    end else begin
      ram_we      = accept && dec.mem_we;
      ram_wr_idx  = dec.wr_idx;
      ram_wr_data = dec.wr_data;
    end
  end

  ccbd_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk       (clk),
    .wr_en     (ram_we),
    .wr_addr   (ram_wr_idx),
    .wr_data   (ram_wr_data),
    .rd_addr_a (dec.rd_idx_lo),
    .rd_addr_b (dec.rd_idx_hi),
    .rd_data_a (rd_lo),
    .rd_data_b (rd_hi)
  );

  always_comb begin
    clr_nxt     = clr_r;
    clr_idx_nxt = clr_idx_r;
    if (clr_r) begin
      clr_idx_nxt = clr_idx_r + store_idx_t'(1);
      if (clr_idx_r == STORE_LAST) begin
        clr_nxt = 1'b0;
      end
    end
    pad_nxt = (accept && dec.pad_we) ? dec.pad_nxt : pad_r;
    vld_nxt = accept;
    src_nxt = dec.src;
    res_nxt = dec.res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_idx_r <= '0;
      pad_r     <= '0;
      vld_r     <= 1'b0;
    end else begin
      clr_r     <= clr_nxt;
      clr_idx_r <= clr_idx_nxt;
      pad_r     <= pad_nxt;
      vld_r     <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    src_r <= src_nxt;
    res_r <= res_nxt;
  end

  // merge store read data into the held result
  always_comb begin
    out_item = res_r;
    case (src_r)
      SRC_BYTE: out_item.read_data = {8'h00, rd_lo};
      SRC_WORD: out_item.read_data = {rd_hi, rd_lo};
      default:  out_item.read_data = res_r.read_data;
    endcase
  end

  assign out_valid = vld_r;

endmodule

`default_nettype wire

>>> sv/ccbd_ram.sv
// ----------------------------------------------------------------------------
// ccbd_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ccbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr_a,
  input  wire logic [AW-1:0]    rd_addr_b,
  output logic      [WIDTH-1:0] rd_data_a,
  output logic      [WIDTH-1:0] rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

`default_nettype wire

>>> sv/ccbd_decode.sv
// ----------------------------------------------------------------------------
// ccbd_decode
// Address mirroring and command decode for one bus transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module ccbd_decode
  import ccbd_pkg::*;
(
  input  wire in_item_t   item,
  input  wire logic [7:0] pad_q,
  output dec_t            dec
);

  logic [15:0] a;
  logic [15:0] fa;
  logic        is_gfx;
  logic [2:0]  reg_no;

  assign a      = item.address;
  assign is_gfx = (a >= GFX_BASE) && (a < GFX_END);
  assign reg_no = a[2:0];

  always_comb begin
    if (a < RAM_END) begin
      fa = a & RAM_MASK;
    end else if (is_gfx) begin
      fa = GFX_BASE | {13'd0, reg_no};
    end else begin
      fa = a;
    end
  end

  always_comb begin
    dec           = '0;
    dec.wr_idx    = store_index(fa);
    dec.wr_data   = item.write_data;
    // high byte of a word: folded address plus one, not folded again
    dec.rd_idx_lo = store_index(fa);
    dec.rd_idx_hi = store_index(16'(fa + 16'd1));
    dec.src       = SRC_DIRECT;
    dec.pad_nxt   = pad_q;

    unique case (item.command)
      CMD_RD_BYTE: begin
        if (is_gfx && (reg_no <= GFX_REG_STATUS || reg_no == GFX_REG_DATA)) begin
          dec.res.target         = TGT_GFX;
          dec.res.register_index = reg_no;
        end else if (fa == PAD_PORT) begin
          // shift out one button bit, fill with ones
          dec.res.target    = TGT_CTRL;
          dec.res.read_data = {15'd0, pad_q[0]};
          dec.pad_we        = 1'b1;
          dec.pad_nxt       = (pad_q >> 1) | PAD_FILL;
        end else begin
          dec.src = SRC_BYTE;
        end
      end
      CMD_RD_WORD: begin
        dec.src = SRC_WORD;
      end
      CMD_WR_BYTE: begin
        if (is_gfx && reg_no != GFX_REG_STATUS) begin
          dec.res.target         = TGT_GFX;
          dec.res.register_index = reg_no;
          dec.res.register_write = 1'b1;
          dec.res.forward_data   = item.write_data;
        end else if (fa == DMA_PORT) begin
          dec.res.target       = TGT_DMA;
          dec.res.forward_data = item.write_data;
        end else if (fa == PAD_PORT && item.write_data == PAD_LOAD) begin
          dec.res.target = TGT_CTRL;
          dec.pad_we     = 1'b1;
          dec.pad_nxt    = item.buttons;
        end else if (fa == PAD_PORT && item.write_data == PAD_IDLE) begin
          dec.res.target = TGT_CTRL;
        end else begin
          dec.mem_we = 1'b1;
        end
      end
      CMD_NONE: begin
        // drop: all-zero result, no state change
      end
    endcase
  end

endmodule

`default_nettype wire

>>> sv/ccbd_checker.sv
// ----------------------------------------------------------------------------
// ccbd_checker
// Port-level checks for the CPU bus decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ccbd_checker
  import ccbd_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      start,
  input wire logic      busy,
  input wire logic      out_valid,
  input wire out_item_t out_item
);

  // every transaction gives exactly one result on the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> out_valid)
    else $error("taken transaction gave no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy))
    else $error("result without a transaction");

  // hold off transactions while the store is cleared after reset
  a_busy_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> busy)
    else $error("not busy right after reset");

  a_fwd_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.target != TGT_GFX) |->
      (out_item.register_index == 3'd0 && out_item.register_write == 1'b0))
    else $error("register fields set on a non-forwarded result");

  a_ctrl_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.target == TGT_CTRL) |->
      (out_item.read_data[15:1] == 15'd0 && out_item.forward_data == 8'd0))
    else $error("controller result carries more than one bit");

endmodule

bind console_cpu_bus_decoder ccbd_checker u_ccbd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);

`default_nettype wire
